// ===== rtl/ktq_pkg.sv =====
// Package: item types, result kinds and sizing constants for the keyed timer queue.
`default_nettype none
package ktq_pkg;
  localparam int CAPACITY_DEF  = 16;
  localparam int SEQ_BITS_DEF  = 8;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_OUT       = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] K_ADDED   = 3'd0;
  localparam logic [2:0] K_DUP     = 3'd1;
  localparam logic [2:0] K_FULL    = 3'd2;
  localparam logic [2:0] K_REMOVED = 3'd3;
  localparam logic [2:0] K_NOMATCH = 3'd4;
  localparam logic [2:0] K_EXPIRED = 3'd5;
  localparam logic [2:0] K_NONE    = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] target;
    logic [9:0]  tag;
    logic [31:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_target;
    logic [9:0]  out_tag;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, clear scan state
    logic scan;      // examine one slot
    logic commit;    // apply add or remove at scan end
    logic tick_adv;  // advance elapsed time
    logic take_best; // retire best due slot
  } ktq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic more_due;  // scan saw at least two due slots
  } ktq_sts_t;
endpackage
`default_nettype wire

// ===== rtl/ktq_datapath.sv =====
// Datapath: slot table, elapsed counter, sequence counter and slot scanner.
`default_nettype none
module ktq_datapath #(
  parameter int CAPACITY  = ktq_pkg::CAPACITY_DEF,
  parameter int SEQ_BITS  = ktq_pkg::SEQ_BITS_DEF,
  parameter int TIME_BITS = ktq_pkg::TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ktq_pkg::in_item_t in_item,
  input  wire ktq_pkg::ktq_cmd_t cmd,
  output ktq_pkg::ktq_sts_t      sts,
  output ktq_pkg::out_item_t     res
);
  import ktq_pkg::*;
  localparam int IW = $clog2(CAPACITY);

  logic [CAPACITY-1:0]  live;
  logic [TIME_BITS-1:0] deadline [CAPACITY];
  logic [SEQ_BITS-1:0]  seqs     [CAPACITY];
  logic [15:0]          owner    [CAPACITY];
  logic [9:0]           label    [CAPACITY];
  logic [TIME_BITS-1:0] elapsed;
  logic [SEQ_BITS-1:0]  seq_cnt;

  in_item_t        item;
  logic [IW:0]     idx;
  logic            match_hit;
  logic [IW-1:0]   match_idx;
  logic            free_hit;
  logic [IW-1:0]   free_idx;
  logic            best_hit;
  logic [IW-1:0]   best_idx;
  logic [TIME_BITS-1:0] best_dl;
  logic [SEQ_BITS-1:0]  best_seq;
  logic            due_seen;
  logic            due_multi;

  logic [IW-1:0]   cur;
  logic            cur_match, cur_due, cur_better;
  logic [TIME_BITS:0] sum;
  logic [TIME_BITS-1:0] new_dl;

  assign cur       = idx[IW-1:0];
  assign cur_match = live[cur] && owner[cur] == item.target && label[cur] == item.tag;
  assign cur_due   = live[cur] && deadline[cur] < elapsed;
  assign cur_better = !best_hit || deadline[cur] < best_dl ||
                      (deadline[cur] == best_dl && seqs[cur] < best_seq);
  assign sum    = {1'b0, elapsed} + {{(TIME_BITS-31){1'b0}}, item.delay_ms};
  assign new_dl = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  assign sts.scan_done  = idx == (IW+1)'(CAPACITY);
  assign sts.best_found = best_hit;
  assign sts.more_due   = due_multi;

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      elapsed <= '0;
      seq_cnt <= '0;
      idx     <= '0;
      res     <= '0;
    end else begin
      if (cmd.load) begin
        item      <= in_item;
        idx       <= '0;
        match_hit <= 1'b0;
        free_hit  <= 1'b0;
        best_hit  <= 1'b0;
        due_seen  <= 1'b0;
        due_multi <= 1'b0;
      end
      if (cmd.tick_adv) begin
        elapsed <= elapsed + 1'b1;
        idx     <= '0;
        best_hit <= 1'b0;
        due_seen  <= 1'b0;
        due_multi <= 1'b0;
      end
      if (cmd.scan) begin
        idx <= idx + 1'b1;
        if (item.operation == OP_TICK) begin
          if (cur_due) begin
            due_seen <= 1'b1;
            if (due_seen) due_multi <= 1'b1;
          end
          if (cur_due && cur_better) begin
            best_hit <= 1'b1;
            best_idx <= cur;
            best_dl  <= deadline[cur];
            best_seq <= seqs[cur];
          end
        end else begin
          if (cur_match && !match_hit) begin
            match_hit <= 1'b1;
            match_idx <= cur;
          end
          if (!live[cur] && !free_hit) begin
            free_hit <= 1'b1;
            free_idx <= cur;
          end
        end
      end
      if (cmd.commit) begin
        res.out_target <= item.target;
        res.out_tag    <= item.tag;
        res.last       <= 1'b1;
        if (item.operation == OP_ADD) begin
          seq_cnt <= seq_cnt + 1'b1;
          if (match_hit) res.kind <= K_DUP;
          else if (!free_hit) res.kind <= K_FULL;
          else begin
            res.kind           <= K_ADDED;
            live[free_idx]     <= 1'b1;
            deadline[free_idx] <= new_dl;
            seqs[free_idx]     <= seq_cnt + 1'b1;
            owner[free_idx]    <= item.target;
            label[free_idx]    <= item.tag;
          end
        end else if (match_hit) begin
          res.kind        <= K_REMOVED;
          live[match_idx] <= 1'b0;
        end else begin
          res.kind <= K_NOMATCH;
        end
      end
      if (cmd.take_best) begin
        if (best_hit) begin
          live[best_idx] <= 1'b0;
          res.kind       <= K_EXPIRED;
          res.out_target <= owner[best_idx];
          res.out_tag    <= label[best_idx];
          res.last       <= 1'b0;
        end else begin
          res <= '{kind: K_NONE, out_target: '0, out_tag: '0, last: 1'b1};
        end
        idx      <= '0;
        best_hit <= 1'b0;
        due_seen  <= 1'b0;
        due_multi <= 1'b0;
      end
    end
  end

  a_commit_op: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> item.operation == OP_ADD || item.operation == OP_REMOVE)
    else $error("commit on a tick item");
  a_take_needs_done: assert property (@(posedge clk) disable iff (rst)
    cmd.take_best |-> sts.scan_done) else $error("retire before scan end");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= (IW+1)'(CAPACITY)) else $error("scan index overrun");
  a_elapsed_step: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_adv |=> elapsed == $past(elapsed) + 1'b1) else $error("elapsed step");
endmodule
`default_nettype wire

// ===== rtl/ktq_ctrl.sv =====
// Controller: sequences load, slot scans, commit and result delivery.
`default_nettype none
module ktq_ctrl #(
  parameter int CAPACITY = ktq_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire ktq_pkg::ktq_sts_t sts,
  output ktq_pkg::ktq_cmd_t      cmd,
  output logic                   mark_last
);
  import ktq_pkg::*;
  localparam int LIMIT = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
  localparam int CW = $clog2(LIMIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;

  logic [2:0]    state, state_next;
  logic          is_tick;
  logic [CW-1:0] count;
  logic          more;    // another expiry scan follows this output

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (accept && in_op != OP_UNUSED) begin
        cmd.load = 1'b1;
        state_next = (in_op == OP_TICK) ? S_TICK : S_SCAN;
      end
      S_TICK: begin
        cmd.tick_adv = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: if (sts.scan_done) begin
        if (is_tick) begin
          cmd.take_best = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end else cmd.scan = 1'b1;
      S_EMIT: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = more ? S_SCAN : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // last mark for expiries: no further scan follows
  assign mark_last = !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_tick <= 1'b0;
      count   <= '0;
      more    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        is_tick <= in_op == OP_TICK;
        count   <= '0;
        more    <= 1'b0;
      end
      if (cmd.take_best) begin
        more  <= sts.best_found && sts.more_due && (count + 1'b1) < CW'(LIMIT);
        count <= count + 1'b1;
      end
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result waits");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.commit, cmd.tick_adv, cmd.take_best}))
    else $error("conflicting commands");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/keyed_timer_queue.sv =====
// Top level: keyed one-shot timer table with cancel.
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall  | ktq_pkg::in_item_t
//   out     | output    | out_valid / out_stall| ktq_pkg::out_item_t
// Add and remove compare one slot per cycle, then commit their result.
// A tick runs one full slot scan for each result. Each expiry scan also notes
// whether a second timer is due; that and the MAX_OUT limit set the last mark.
// Reset (rst, synchronous) clears live flags, elapsed time and the sequence counter.
// The output register holds a result under out_stall; input is stalled meanwhile.
`default_nettype none
module keyed_timer_queue #(
  parameter int CAPACITY  = ktq_pkg::CAPACITY_DEF,
  parameter int SEQ_BITS  = ktq_pkg::SEQ_BITS_DEF,
  parameter int TIME_BITS = ktq_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ktq_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ktq_pkg::out_item_t      out_item
);
  import ktq_pkg::*;

  ktq_cmd_t  cmd;
  ktq_sts_t  sts;
  out_item_t res;
  logic      mark_last;
  logic      cv;

  ktq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk, .rst, .in_valid, .in_op(in_item.operation), .in_stall,
    .out_valid(cv), .out_stall, .sts, .cmd, .mark_last
  );

  ktq_datapath #(.CAPACITY(CAPACITY), .SEQ_BITS(SEQ_BITS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .in_item, .cmd, .sts, .res
  );

  assign out_valid = cv;
  always_comb begin
    out_item = res;
    if (res.kind == K_EXPIRED)
      out_item.last = mark_last;
  end
endmodule
`default_nettype wire
